// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHECK_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/rmfd_pkg.sv =====
`default_nettype none

package rmfd_pkg;

   localparam int ADDR_W = 8;
   localparam int ADDR_SPACE = 1 << ADDR_W;
   localparam int ID_W = 8;
   localparam int CNT_W = 32;
   localparam int KIND_W = 2;
   localparam int VERDICT_W = 3;
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;

   localparam logic [VERDICT_W-1:0] V_NOT_ADDRESSED = 3'd0;
   localparam logic [VERDICT_W-1:0] V_DELIVERED     = 3'd1;
   localparam logic [VERDICT_W-1:0] V_DUPLICATE     = 3'd2;
   localparam logic [VERDICT_W-1:0] V_ACK_MATCHED   = 3'd3;
   localparam logic [VERDICT_W-1:0] V_ACK_IGNORED   = 3'd4;

   localparam logic [1:0] REG_OWN_MAC   = 2'd0;
   localparam logic [1:0] REG_OWN_NET   = 2'd1;
   localparam logic [1:0] REG_MAC_BCAST = 2'd2;
   localparam logic [1:0] REG_NET_BCAST = 2'd3;

   localparam logic [ADDR_W-1:0] RST_OWN_MAC   = 8'd0;
   localparam logic [ADDR_W-1:0] RST_OWN_NET   = 8'd0;
   localparam logic [ADDR_W-1:0] RST_MAC_BCAST = 8'd255;
   localparam logic [ADDR_W-1:0] RST_NET_BCAST = 8'd255;

   typedef struct packed {
      logic [ADDR_W-1:0] own_mac;
      logic [ADDR_W-1:0] own_net;
      logic [ADDR_W-1:0] mac_bcast;
      logic [ADDR_W-1:0] net_bcast;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/rmfd_csr.sv =====
`default_nettype none

module rmfd_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [rmfd_pkg::PADDR_W-1:0] paddr,
   input  wire logic [rmfd_pkg::PDATA_W-1:0] pwdata,
   output logic      [rmfd_pkg::PDATA_W-1:0] prdata,
   output logic                              pready,
   output rmfd_pkg::cfg_type                 cfg
);

   rmfd_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [1:0]        reg_idx;
   logic [rmfd_pkg::ADDR_W-1:0] wr_val;
   logic [rmfd_pkg::ADDR_W-1:0] rd_val;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign wr_val  = pwdata[rmfd_pkg::ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_mac   <= rmfd_pkg::RST_OWN_MAC;
         cfg_ff.own_net   <= rmfd_pkg::RST_OWN_NET;
         cfg_ff.mac_bcast <= rmfd_pkg::RST_MAC_BCAST;
         cfg_ff.net_bcast <= rmfd_pkg::RST_NET_BCAST;
      end else if (wr_en) begin
         case (reg_idx)
            rmfd_pkg::REG_OWN_MAC:   cfg_ff.own_mac   <= wr_val;
            rmfd_pkg::REG_OWN_NET:   cfg_ff.own_net   <= wr_val;
            rmfd_pkg::REG_MAC_BCAST: cfg_ff.mac_bcast <= wr_val;
            rmfd_pkg::REG_NET_BCAST: cfg_ff.net_bcast <= wr_val;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         rmfd_pkg::REG_OWN_MAC:   rd_val = cfg_ff.own_mac;
         rmfd_pkg::REG_OWN_NET:   rd_val = cfg_ff.own_net;
         rmfd_pkg::REG_MAC_BCAST: rd_val = cfg_ff.mac_bcast;
         rmfd_pkg::REG_NET_BCAST: rd_val = cfg_ff.net_bcast;
         default:                 rd_val = '0;
      endcase
   end

   assign prdata = {{(rmfd_pkg::PDATA_W - rmfd_pkg::ADDR_W){1'b0}}, rd_val};
   assign cfg    = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/rmfd_id_table.sv =====
`default_nettype none

module rmfd_id_table #(
   parameter int NUM_SOURCES = 256,
   parameter int IDX_W = $clog2(NUM_SOURCES)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      rd_en,
   input  wire logic [IDX_W-1:0]          rd_idx,
   output logic      [rmfd_pkg::ID_W-1:0] rd_data,
   input  wire logic                      wr_en,
   input  wire logic [IDX_W-1:0]          wr_idx,
   input  wire logic [rmfd_pkg::ID_W-1:0] wr_data
);

   logic [rmfd_pkg::ID_W-1:0] mem [NUM_SOURCES];
   logic [NUM_SOURCES-1:0]    valid_ff;
   logic [rmfd_pkg::ID_W-1:0] rd_q_ff;
   logic                      rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_idx];
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_idx];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/mac_receive_filter_dedup.sv =====
`default_nettype none
`include "assert_macros.svh"

// channel   direction  handshake             payload
// request   in         start high, busy low  req_* header fields
// result    out        rsp_valid, one cycle  rsp_* verdict, ack fields, totals
// config    in/out     apb write/read        paddr, pwdata, prdata
//
// an item is handled as the id table read at the accept edge, then
// decision and write-back; busy is high in the decision state, which keeps
// the table read of the next item behind the previous write-back.
// the result appears in the cycle after that and cannot be stalled.
// reset is synchronous; the id table valid bits clear at once, so the
// table reads as zero straight out of reset with no clearing pass.

module mac_receive_filter_dedup #(
   parameter int NUM_SOURCES = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [rmfd_pkg::ADDR_W-1:0]         req_mac_destination,
   input  wire logic [rmfd_pkg::ADDR_W-1:0]         req_mac_source,
   input  wire logic [rmfd_pkg::ADDR_W-1:0]         req_net_destination,
   input  wire logic [rmfd_pkg::KIND_W-1:0]         req_packet_kind,
   input  wire logic                                req_ack_requested,
   input  wire logic [rmfd_pkg::ID_W-1:0]           req_packet_id,
   input  wire logic [rmfd_pkg::ID_W-1:0]           req_awaited_ack_id,
   output logic                                     rsp_valid,
   output logic      [rmfd_pkg::VERDICT_W-1:0]      rsp_verdict,
   output logic                                     rsp_send_ack,
   output logic      [rmfd_pkg::ADDR_W-1:0]         rsp_ack_mac_destination,
   output logic      [rmfd_pkg::ADDR_W-1:0]         rsp_ack_net_source,
   output logic      [rmfd_pkg::ID_W-1:0]           rsp_ack_packet_id,
   output logic      [rmfd_pkg::CNT_W-1:0]          rsp_received_total,
   output logic      [rmfd_pkg::CNT_W-1:0]          rsp_dropped_total,
   output logic      [rmfd_pkg::CNT_W-1:0]          rsp_acks_sent_total,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [rmfd_pkg::PADDR_W-1:0]        paddr,
   input  wire logic [rmfd_pkg::PDATA_W-1:0]        pwdata,
   output logic      [rmfd_pkg::PDATA_W-1:0]        prdata,
   output logic                                     pready
);

   localparam int IDX_W = $clog2(NUM_SOURCES);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EVAL = 1'b1;

   rmfd_pkg::cfg_type cfg;

   logic state_ff;
   logic state_in;
   logic accept;

   logic [IDX_W-1:0] src_idx_lut [rmfd_pkg::ADDR_SPACE];

   logic [rmfd_pkg::ADDR_W-1:0]  mdst_ff;
   logic [rmfd_pkg::ADDR_W-1:0]  msrc_ff;
   logic [rmfd_pkg::ADDR_W-1:0]  ndst_ff;
   logic [rmfd_pkg::KIND_W-1:0]  kind_ff;
   logic                         ackreq_ff;
   logic [rmfd_pkg::ID_W-1:0]    pid_ff;
   logic [rmfd_pkg::ID_W-1:0]    await_ff;
   logic [IDX_W-1:0]             idx_ff;

   logic [rmfd_pkg::ID_W-1:0]    last_id;
   logic                         eval;
   logic                         is_bcast;
   logic                         addressed;
   logic                         ack_path;
   logic                         dup;
   logic                         tbl_wr;
   logic [rmfd_pkg::VERDICT_W-1:0] verdict;

   logic [rmfd_pkg::CNT_W-1:0]   recv_ff;
   logic [rmfd_pkg::CNT_W-1:0]   drop_ff;
   logic [rmfd_pkg::CNT_W-1:0]   acks_ff;

   logic                           rsp_valid_ff;
   logic [rmfd_pkg::VERDICT_W-1:0] rsp_verdict_ff;
   logic                           rsp_send_ff;
   logic [rmfd_pkg::ADDR_W-1:0]    rsp_adst_ff;
   logic [rmfd_pkg::ADDR_W-1:0]    rsp_asrc_ff;
   logic [rmfd_pkg::ID_W-1:0]      rsp_apid_ff;

   rmfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   for (genvar gi = 0; gi < rmfd_pkg::ADDR_SPACE; gi++) begin : g_idx_lut
      assign src_idx_lut[gi] = IDX_W'(gi % NUM_SOURCES);
   end

   assign busy   = (state_ff == ST_EVAL);
   assign accept = start && !busy;
   assign eval   = (state_ff == ST_EVAL);

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = accept ? ST_EVAL : ST_IDLE;
         ST_EVAL: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mdst_ff   <= req_mac_destination;
         msrc_ff   <= req_mac_source;
         ndst_ff   <= req_net_destination;
         kind_ff   <= req_packet_kind;
         ackreq_ff <= req_ack_requested;
         pid_ff    <= req_packet_id;
         await_ff  <= req_awaited_ack_id;
         idx_ff    <= src_idx_lut[req_mac_source];
      end
   end

   rmfd_id_table #(
      .NUM_SOURCES (NUM_SOURCES),
      .IDX_W       (IDX_W)
   ) u_id_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_idx  (src_idx_lut[req_mac_source]),
      .rd_data (last_id),
      .wr_en   (tbl_wr),
      .wr_idx  (idx_ff),
      .wr_data (pid_ff)
   );

   assign is_bcast  = (mdst_ff == cfg.mac_bcast);
   assign addressed = is_bcast || (mdst_ff == cfg.own_mac);
   assign ack_path  = addressed && (kind_ff == rmfd_pkg::KIND_DATA) && ackreq_ff
                      && !is_bcast && (ndst_ff != cfg.net_bcast);
   assign dup       = (last_id == pid_ff);
   assign tbl_wr    = eval && ack_path && !dup;

   always_comb begin
      if (!addressed) begin
         verdict = rmfd_pkg::V_NOT_ADDRESSED;
      end else if (ack_path) begin
         verdict = dup ? rmfd_pkg::V_DUPLICATE : rmfd_pkg::V_DELIVERED;
      end else if (kind_ff == rmfd_pkg::KIND_ACK) begin
         verdict = (pid_ff == await_ff) ? rmfd_pkg::V_ACK_MATCHED
                                        : rmfd_pkg::V_ACK_IGNORED;
      end else begin
         verdict = rmfd_pkg::V_DELIVERED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recv_ff      <= '0;
         drop_ff      <= '0;
         acks_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= eval;
         if (eval && addressed) begin
            recv_ff <= recv_ff + 1'b1;
         end
         if (eval && !addressed) begin
            drop_ff <= drop_ff + 1'b1;
         end
         if (eval && ack_path) begin
            acks_ff <= acks_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (eval) begin
         rsp_verdict_ff <= verdict;
         rsp_send_ff    <= ack_path;
         rsp_adst_ff    <= ack_path ? msrc_ff : '0;
         rsp_asrc_ff    <= ack_path ? cfg.own_net : '0;
         rsp_apid_ff    <= ack_path ? pid_ff : '0;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_verdict             = rsp_verdict_ff;
   assign rsp_send_ack            = rsp_send_ff;
   assign rsp_ack_mac_destination = rsp_adst_ff;
   assign rsp_ack_net_source      = rsp_asrc_ff;
   assign rsp_ack_packet_id       = rsp_apid_ff;
   assign rsp_received_total      = recv_ff;
   assign rsp_dropped_total       = drop_ff;
   assign rsp_acks_sent_total     = acks_ff;

   `CHECK_NEXT(a_rsp_follows_eval, clock, reset, busy, rsp_valid && !busy)
   `CHECK_SAME(a_no_rsp_while_busy, clock, reset, rsp_valid, !busy)
   `CHECK_SAME(a_ack_only_on_data, clock, reset, rsp_valid && rsp_send_ack,
      rsp_verdict == rmfd_pkg::V_DELIVERED || rsp_verdict == rmfd_pkg::V_DUPLICATE)
   `CHECK_SAME(a_drop_counted, clock, reset,
      rsp_valid && rsp_verdict == rmfd_pkg::V_NOT_ADDRESSED,
      rsp_dropped_total == rmfd_pkg::CNT_W'($past(rsp_dropped_total) + 1'b1))

endmodule

`default_nettype wire

// ===== dv/rmfd_checker.sv =====
module rmfd_checker #(
   parameter int NUM_SOURCES = 256
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic                             busy,
   input  wire logic [rmfd_pkg::ADDR_W-1:0]      req_mac_destination,
   input  wire logic [rmfd_pkg::ADDR_W-1:0]      req_mac_source,
   input  wire logic [rmfd_pkg::ADDR_W-1:0]      req_net_destination,
   input  wire logic [rmfd_pkg::KIND_W-1:0]      req_packet_kind,
   input  wire logic                             req_ack_requested,
   input  wire logic [rmfd_pkg::ID_W-1:0]        req_packet_id,
   input  wire logic [rmfd_pkg::ID_W-1:0]        req_awaited_ack_id,
   input  wire logic                             rsp_valid,
   input  wire logic [rmfd_pkg::VERDICT_W-1:0]   rsp_verdict,
   input  wire logic                             rsp_send_ack,
   input  wire logic [rmfd_pkg::ADDR_W-1:0]      rsp_ack_mac_destination,
   input  wire logic [rmfd_pkg::ADDR_W-1:0]      rsp_ack_net_source,
   input  wire logic [rmfd_pkg::ID_W-1:0]        rsp_ack_packet_id,
   input  wire logic [rmfd_pkg::CNT_W-1:0]       rsp_received_total,
   input  wire logic [rmfd_pkg::CNT_W-1:0]       rsp_dropped_total,
   input  wire logic [rmfd_pkg::CNT_W-1:0]       rsp_acks_sent_total,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [rmfd_pkg::PADDR_W-1:0]     paddr,
   input  wire logic [rmfd_pkg::PDATA_W-1:0]     pwdata,
   input  wire logic                             pready,
   output logic      [31:0]                      fail_count,
   output logic      [31:0]                      pending
);
   import rmfd_pkg::*;

   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic                 send_ack;
      logic [ADDR_W-1:0]    ack_dst;
      logic [ADDR_W-1:0]    ack_src;
      logic [ID_W-1:0]      ack_id;
      logic [CNT_W-1:0]     rx_total;
      logic [CNT_W-1:0]     drop_total;
      logic [CNT_W-1:0]     ack_total;
   } header_outcome_t;

   logic [ADDR_W-1:0] own_mac;
   logic [ADDR_W-1:0] own_net;
   logic [ADDR_W-1:0] mac_bcast;
   logic [ADDR_W-1:0] net_bcast;
   logic [ID_W-1:0]   seen_id [NUM_SOURCES];
   logic [CNT_W-1:0]  rx_cnt;
   logic [CNT_W-1:0]  drop_cnt;
   logic [CNT_W-1:0]  ack_cnt;
   header_outcome_t   outcome_q[$];
   int                errors = 0;

   function automatic header_outcome_t filter_header(
      input logic [ADDR_W-1:0] mdst,
      input logic [ADDR_W-1:0] msrc,
      input logic [ADDR_W-1:0] ndst,
      input logic [KIND_W-1:0] kind,
      input logic              ack_req,
      input logic [ID_W-1:0]   pid,
      input logic [ID_W-1:0]   aid
   );
      header_outcome_t o;
      logic            is_bcast;
      int              idx;
      o = '0;
      is_bcast = (mdst == mac_bcast);
      if (mdst == own_mac || is_bcast) begin
         rx_cnt = rx_cnt + 1;
         if (kind == KIND_DATA && ack_req && !is_bcast && ndst != net_bcast) begin
            idx = int'(msrc) % NUM_SOURCES;
            ack_cnt = ack_cnt + 1;
            o.send_ack = 1'b1;
            o.ack_dst = msrc;
            o.ack_src = own_net;
            o.ack_id = pid;
            if (seen_id[idx] == pid) begin
               o.verdict = V_DUPLICATE;
            end else begin
               seen_id[idx] = pid;
               o.verdict = V_DELIVERED;
            end
         end else if (kind == KIND_ACK) begin
            o.verdict = (pid == aid) ? V_ACK_MATCHED : V_ACK_IGNORED;
         end else begin
            o.verdict = V_DELIVERED;
         end
      end else begin
         drop_cnt = drop_cnt + 1;
         o.verdict = V_NOT_ADDRESSED;
      end
      o.rx_total = rx_cnt;
      o.drop_total = drop_cnt;
      o.ack_total = ack_cnt;
      return o;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 10)
            $display("mismatch on %s: expected %0h, got %0h", label, want, got);
      end
   endtask

   always @(posedge clock) begin
      header_outcome_t want;
      if (reset) begin
         own_mac = RST_OWN_MAC;
         own_net = RST_OWN_NET;
         mac_bcast = RST_MAC_BCAST;
         net_bcast = RST_NET_BCAST;
         for (int i = 0; i < NUM_SOURCES; i++)
            seen_id[i] = '0;
         rx_cnt = '0;
         drop_cnt = '0;
         ack_cnt = '0;
         outcome_q.delete();
      end else begin
         if (rsp_valid) begin
            if (outcome_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("result with no item outstanding, verdict %0d", rsp_verdict);
            end else begin
               want = outcome_q.pop_front();
               check_field("verdict", 32'(want.verdict), 32'(rsp_verdict));
               check_field("send_ack", 32'(want.send_ack), 32'(rsp_send_ack));
               check_field("ack_mac_destination", 32'(want.ack_dst),
                           32'(rsp_ack_mac_destination));
               check_field("ack_net_source", 32'(want.ack_src), 32'(rsp_ack_net_source));
               check_field("ack_packet_id", 32'(want.ack_id), 32'(rsp_ack_packet_id));
               check_field("received_total", want.rx_total, rsp_received_total);
               check_field("dropped_total", want.drop_total, rsp_dropped_total);
               check_field("acks_sent_total", want.ack_total, rsp_acks_sent_total);
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_OWN_MAC:   own_mac = pwdata[ADDR_W-1:0];
               REG_OWN_NET:   own_net = pwdata[ADDR_W-1:0];
               REG_MAC_BCAST: mac_bcast = pwdata[ADDR_W-1:0];
               REG_NET_BCAST: net_bcast = pwdata[ADDR_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy)
            outcome_q.push_back(filter_header(req_mac_destination, req_mac_source,
                                              req_net_destination, req_packet_kind,
                                              req_ack_requested, req_packet_id,
                                              req_awaited_ack_id));
      end
      fail_count <= errors;
      pending <= outcome_q.size();
   end

endmodule

// ===== dv/testbench.sv =====
module testbench;
   import rmfd_pkg::*;

   localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [ADDR_W-1:0]     req_mac_destination = '0;
   logic [ADDR_W-1:0]     req_mac_source = '0;
   logic [ADDR_W-1:0]     req_net_destination = '0;
   logic [KIND_W-1:0]     req_packet_kind = '0;
   logic                  req_ack_requested = 1'b0;
   logic [ID_W-1:0]       req_packet_id = '0;
   logic [ID_W-1:0]       req_awaited_ack_id = '0;
   logic                  rsp_valid;
   logic [VERDICT_W-1:0]  rsp_verdict;
   logic                  rsp_send_ack;
   logic [ADDR_W-1:0]     rsp_ack_mac_destination;
   logic [ADDR_W-1:0]     rsp_ack_net_source;
   logic [ID_W-1:0]       rsp_ack_packet_id;
   logic [CNT_W-1:0]      rsp_received_total;
   logic [CNT_W-1:0]      rsp_dropped_total;
   logic [CNT_W-1:0]      rsp_acks_sent_total;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [PADDR_W-1:0]    paddr = '0;
   logic [PDATA_W-1:0]    pwdata = '0;
   logic [PDATA_W-1:0]    prdata;
   logic                  pready;
   logic [31:0]           fail_count;
   logic [31:0]           pending;

   logic [ADDR_W-1:0]     cur_own_mac = RST_OWN_MAC;
   logic [ADDR_W-1:0]     cur_mac_bcast = RST_MAC_BCAST;
   logic [ADDR_W-1:0]     cur_net_bcast = RST_NET_BCAST;
   int                    burst_left = 0;

   mac_receive_filter_dedup u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mac_destination(req_mac_destination), .req_mac_source(req_mac_source),
      .req_net_destination(req_net_destination), .req_packet_kind(req_packet_kind),
      .req_ack_requested(req_ack_requested), .req_packet_id(req_packet_id),
      .req_awaited_ack_id(req_awaited_ack_id),
      .rsp_valid(rsp_valid), .rsp_verdict(rsp_verdict), .rsp_send_ack(rsp_send_ack),
      .rsp_ack_mac_destination(rsp_ack_mac_destination),
      .rsp_ack_net_source(rsp_ack_net_source), .rsp_ack_packet_id(rsp_ack_packet_id),
      .rsp_received_total(rsp_received_total), .rsp_dropped_total(rsp_dropped_total),
      .rsp_acks_sent_total(rsp_acks_sent_total),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   rmfd_checker #(.NUM_SOURCES(256)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mac_destination(req_mac_destination), .req_mac_source(req_mac_source),
      .req_net_destination(req_net_destination), .req_packet_kind(req_packet_kind),
      .req_ack_requested(req_ack_requested), .req_packet_id(req_packet_id),
      .req_awaited_ack_id(req_awaited_ack_id),
      .rsp_valid(rsp_valid), .rsp_verdict(rsp_verdict), .rsp_send_ack(rsp_send_ack),
      .rsp_ack_mac_destination(rsp_ack_mac_destination),
      .rsp_ack_net_source(rsp_ack_net_source), .rsp_ack_packet_id(rsp_ack_packet_id),
      .rsp_received_total(rsp_received_total), .rsp_dropped_total(rsp_dropped_total),
      .rsp_acks_sent_total(rsp_acks_sent_total),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("testbench: errors");
      $finish;
   end

   task automatic send_header(
      input logic [ADDR_W-1:0] mdst,
      input logic [ADDR_W-1:0] msrc,
      input logic [ADDR_W-1:0] ndst,
      input logic [KIND_W-1:0] kind,
      input logic              ack_req,
      input logic [ID_W-1:0]   pid,
      input logic [ID_W-1:0]   aid,
      input int                gap
   );
      start <= 1'b1;
      req_mac_destination <= mdst;
      req_mac_source <= msrc;
      req_net_destination <= ndst;
      req_packet_kind <= kind;
      req_ack_requested <= ack_req;
      req_packet_id <= pid;
      req_awaited_ack_id <= aid;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= ($urandom() & 32'hFFFF_FF00) | 32'(val);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_OWN_MAC:   cur_own_mac = val;
         REG_MAC_BCAST: cur_mac_bcast = val;
         REG_NET_BCAST: cur_net_bcast = val;
         default: ;
      endcase
   endtask

   task automatic random_header();
      logic [ADDR_W-1:0] mdst;
      logic [ADDR_W-1:0] msrc;
      logic [ADDR_W-1:0] ndst;
      logic [KIND_W-1:0] kind;
      logic              ack_req;
      logic [ID_W-1:0]   pid;
      logic [ID_W-1:0]   aid;
      int                r;
      int                gap;
      r = $urandom_range(0, 99);
      if (r < 55)
         mdst = cur_own_mac;
      else if (r < 70)
         mdst = cur_mac_bcast;
      else
         mdst = ADDR_W'($urandom_range(0, 255));
      msrc = ($urandom_range(0, 9) < 6) ? ADDR_W'($urandom_range(0, 7))
                                         : ADDR_W'($urandom_range(0, 255));
      ndst = ($urandom_range(0, 9) == 0) ? cur_net_bcast : ADDR_W'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 60)
         kind = KIND_DATA;
      else if (r < 75)
         kind = KIND_ACK;
      else
         kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE : KIND_OTHER;
      ack_req = ($urandom_range(0, 4) != 0);
      pid = ($urandom_range(0, 1) != 0) ? ID_W'($urandom_range(0, 3))
                                        : ID_W'($urandom_range(0, 255));
      aid = ($urandom_range(0, 1) != 0) ? pid : ID_W'($urandom_range(0, 255));
      // some plain noise
      if ($urandom_range(0, 19) == 0) begin
         mdst = ADDR_W'($urandom_range(0, 255));
         msrc = ADDR_W'($urandom_range(0, 255));
         ndst = ADDR_W'($urandom_range(0, 255));
         kind = KIND_W'($urandom_range(0, 3));
         ack_req = 1'($urandom_range(0, 1));
         pid = ID_W'($urandom_range(0, 255));
         aid = ID_W'($urandom_range(0, 255));
      end
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(10, 40);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 8);
      end
      send_header(mdst, msrc, ndst, kind, ack_req, pid, aid, gap);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_header(8'h55, 8'h01, 8'h00, KIND_DATA, 1'b1, 8'h10, 8'h00, 0);
      send_header(8'h00, 8'h00, 8'h00, KIND_DATA, 1'b1, 8'h00, 8'h00, 1);
      send_header(8'h00, 8'h00, 8'h00, KIND_DATA, 1'b1, 8'h05, 8'h00, 0);
      send_header(8'h00, 8'h00, 8'h00, KIND_DATA, 1'b1, 8'h05, 8'h00, 2);
      send_header(8'h00, 8'hFF, 8'h01, KIND_DATA, 1'b1, 8'hFF, 8'hFF, 8);
      send_header(8'h00, 8'hFF, 8'h01, KIND_DATA, 1'b1, 8'hFF, 8'h00, 0);
      send_header(8'h00, 8'h03, 8'h01, KIND_DATA, 1'b0, 8'h07, 8'h00, 1);
      send_header(8'hFF, 8'h04, 8'h01, KIND_DATA, 1'b1, 8'h09, 8'h00, 0);
      send_header(8'h00, 8'h04, 8'hFF, KIND_DATA, 1'b1, 8'h09, 8'h00, 3);
      send_header(8'h00, 8'h04, 8'h01, KIND_DATA, 1'b1, 8'h09, 8'h00, 0);
      send_header(8'h00, 8'h06, 8'h02, KIND_ACK, 1'b0, 8'h22, 8'h22, 0);
      send_header(8'h00, 8'h06, 8'h02, KIND_ACK, 1'b1, 8'h22, 8'h23, 1);
      send_header(8'h00, 8'h06, 8'h02, KIND_OTHER, 1'b1, 8'h40, 8'h00, 0);
      send_header(8'h00, 8'h06, 8'h02, KIND_SPARE, 1'b1, 8'h41, 8'h00, 5);
      send_header(8'hFE, 8'hFF, 8'hFF, KIND_SPARE, 1'b1, 8'hFF, 8'hFF, 0);
      send_header(8'hFF, 8'hFF, 8'hFF, KIND_SPARE, 1'b1, 8'hFF, 8'hFF, 0);
      send_header(8'h00, 8'h00, 8'h00, KIND_ACK, 1'b0, 8'h00, 8'h00, 0);
      send_header(8'h01, 8'h00, 8'h00, KIND_ACK, 1'b1, 8'h00, 8'h01, 4);
      send_header(8'h00, 8'h80, 8'hFE, KIND_DATA, 1'b1, 8'h80, 8'h7F, 0);
      send_header(8'h00, 8'h80, 8'hFE, KIND_DATA, 1'b1, 8'h80, 8'h7F, 0);

      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               write_reg(REG_OWN_MAC, 8'h12);
               write_reg(REG_OWN_NET, 8'h34);
               write_reg(REG_MAC_BCAST, 8'hFF);
               write_reg(REG_NET_BCAST, 8'hFF);
            end
            1: begin
               write_reg(REG_OWN_MAC, 8'hFF);
               write_reg(REG_OWN_NET, 8'hFF);
               write_reg(REG_MAC_BCAST, 8'h00);
               write_reg(REG_NET_BCAST, 8'h00);
            end
            2: begin
               // own mac equal to broadcast
               write_reg(REG_OWN_MAC, 8'h00);
               write_reg(REG_OWN_NET, 8'h00);
               write_reg(REG_MAC_BCAST, 8'h00);
               write_reg(REG_NET_BCAST, 8'hFF);
            end
            3: begin
               write_reg(REG_OWN_MAC, 8'hA5);
               write_reg(REG_OWN_NET, 8'h5A);
               write_reg(REG_MAC_BCAST, 8'hA5);
               write_reg(REG_NET_BCAST, 8'h80);
            end
            default: begin
               write_reg(REG_OWN_MAC, ADDR_W'($urandom_range(0, 255)));
               write_reg(REG_OWN_NET, ADDR_W'($urandom_range(0, 255)));
               write_reg(REG_MAC_BCAST, ADDR_W'($urandom_range(0, 255)));
               write_reg(REG_NET_BCAST, ADDR_W'($urandom_range(0, 255)));
            end
         endcase
         @(posedge clock);
         for (int n = 0; n < 290; n++) begin
            random_header();
            if ($urandom_range(0, 49) == 0)
               wait_idle();
         end
      end

      wait_idle();
      if (fail_count == 0 && pending == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
